### design/l2n_pkg.sv
// Package for the row L2 normalization block.
// Holds the controller state type, the command and status structs and the step counts.
// No dependencies.
`default_nettype none
package l2n_pkg;

    localparam int unsigned SQRT_STEPS = 32;
    localparam int unsigned DEN_STEPS  = 32;
    localparam int unsigned NUM_STEPS  = 16;
    localparam int unsigned DIV_STEPS  = 36;
    localparam int unsigned STEP_W     = 6;

    localparam logic REG_MODE       = 1'b0;
    localparam logic REG_ROW_LENGTH = 1'b1;

    typedef enum logic [10:0] {
        ST_LOAD  = 11'b00000000001,
        ST_PREP  = 11'b00000000010,
        ST_SQRT  = 11'b00000000100,
        ST_DINIT = 11'b00000001000,
        ST_DMUL  = 11'b00000010000,
        ST_FETCH = 11'b00000100000,
        ST_NINIT = 11'b00001000000,
        ST_NMUL  = 11'b00010000000,
        ST_QINIT = 11'b00100000000,
        ST_DIV   = 11'b01000000000,
        ST_EMIT  = 11'b10000000000
    } t_state;

    typedef struct packed {
        logic load_en;
        logic prep;
        logic sqrt_step;
        logic den_init;
        logic den_step;
        logic fetch;
        logic num_init;
        logic num_step;
        logic num_last;
        logic quo_init;
        logic div_step;
        logic div_first;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic row_done;
        logic last_elem;
        logic out_free;
        logic backward;
    } t_status;

endpackage
`default_nettype wire

### design/l2n_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module l2n_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire                                   i_clk,
    input  wire                                   i_we,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]                      i_wdata,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### design/l2n_ctrl.sv
// Controller state machine of the row L2 normalization block.
// Sequences load, root, denominator, numerator, divide and emit. Uses l2n_pkg.
`default_nettype none
module l2n_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire l2n_pkg::t_status i_status,
    output l2n_pkg::t_cmd        o_cmd
);

    localparam int unsigned STEP_W = l2n_pkg::STEP_W;

    l2n_pkg::t_state r_state, n_state;
    logic [l2n_pkg::STEP_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= l2n_pkg::ST_LOAD;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            l2n_pkg::ST_LOAD: begin
                o_cmd.load_en = 1'b1;
                if (i_status.row_done) begin
                    n_state = l2n_pkg::ST_PREP;
                end
            end
            l2n_pkg::ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_cnt      = '0;
                n_state    = l2n_pkg::ST_SQRT;
            end
            l2n_pkg::ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == STEP_W'(l2n_pkg::SQRT_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = l2n_pkg::ST_DINIT;
                end
            end
            l2n_pkg::ST_DINIT: begin
                o_cmd.den_init = 1'b1;
                n_state        = l2n_pkg::ST_DMUL;
            end
            l2n_pkg::ST_DMUL: begin
                o_cmd.den_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == STEP_W'(l2n_pkg::DEN_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = l2n_pkg::ST_FETCH;
                end
            end
            l2n_pkg::ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = l2n_pkg::ST_NINIT;
            end
            l2n_pkg::ST_NINIT: begin
                o_cmd.num_init = 1'b1;
                n_cnt          = '0;
                n_state        = i_status.backward ? l2n_pkg::ST_NMUL : l2n_pkg::ST_QINIT;
            end
            l2n_pkg::ST_NMUL: begin
                o_cmd.num_step = 1'b1;
                o_cmd.num_last = (r_cnt == STEP_W'(l2n_pkg::NUM_STEPS - 1));
                n_cnt          = r_cnt + 1'b1;
                if (o_cmd.num_last) begin
                    n_cnt   = '0;
                    n_state = l2n_pkg::ST_QINIT;
                end
            end
            l2n_pkg::ST_QINIT: begin
                o_cmd.quo_init = 1'b1;
                n_cnt          = '0;
                n_state        = l2n_pkg::ST_DIV;
            end
            l2n_pkg::ST_DIV: begin
                o_cmd.div_step  = 1'b1;
                o_cmd.div_first = (r_cnt == '0);
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == STEP_W'(l2n_pkg::DIV_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = l2n_pkg::ST_EMIT;
                end
            end
            l2n_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_status.last_elem ? l2n_pkg::ST_LOAD : l2n_pkg::ST_FETCH;
                end
            end
            default: begin
                n_state = l2n_pkg::ST_LOAD;
                n_cnt   = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

### design/l2n_dp.sv
// Datapath of the row L2 normalization block: sums, row buffer, root, multiply,
// divide and output register. Uses l2n_pkg and l2n_ram.
`default_nettype none
module l2n_dp #(
    parameter int unsigned ROW_MAX = 64
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire l2n_pkg::t_cmd i_cmd,
    output l2n_pkg::t_status o_status,
    input  wire              i_cfg_wr_en,
    input  wire              i_cfg_index,
    input  wire  [6:0]       i_cfg_data,
    input  wire              i_s_tvalid,
    input  wire  [31:0]      i_s_tdata,
    input  wire              i_s_tlast,
    input  wire              i_m_tready,
    output logic             o_valid,
    output logic [31:0]      o_value,
    output logic [5:0]       o_index,
    output logic             o_last,
    output logic             o_batch,
    output logic             o_sat
);

    localparam int unsigned AW = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
    localparam int unsigned CW = $clog2(ROW_MAX + 1);

    logic             r_mode;
    logic [6:0]       r_row_len;
    logic [36:0]      r_ssum;
    logic signed [37:0] r_dsum;
    logic [CW-1:0]    r_count;
    logic             r_seen;
    logic [AW-1:0]    r_k;

    logic [36:0]      r_sc;
    logic [63:0]      r_sv, r_sres, r_sbit;
    logic [68:0]      r_den, r_ssh;
    logic [31:0]      r_rsh;
    logic signed [15:0] r_x;
    logic signed [55:0] r_acc, r_ms, r_md;
    logic [15:0]      r_mx, r_mg;
    logic             r_neg, r_ovf;
    logic [84:0]      r_rem;
    logic [103:0]     r_dsh;
    logic [68:0]      r_dv;
    logic [34:0]      r_q;

    logic             w_accept;
    logic [6:0]       w_len;
    logic [AW-1:0]    w_idx;
    logic signed [15:0] w_fx, w_gx;
    logic signed [31:0] w_sq, w_xg;
    logic [31:0]      w_rd;
    logic [63:0]      w_rb;
    logic signed [55:0] w_tg, w_tx;
    logic [55:0]      w_mag;
    logic             w_ge;
    logic             w_round;
    logic [35:0]      w_qr, w_lim, w_m;
    logic             w_sat;

    assign w_fx     = i_s_tdata[15:0];
    assign w_gx     = i_s_tdata[31:16];
    assign w_sq     = w_fx * w_fx;
    assign w_xg     = w_fx * w_gx;
    assign w_accept = i_cmd.load_en && i_s_tvalid;
    assign w_len    = (r_row_len == 7'd0) ? 7'd1 :
                      ((r_row_len > 7'(ROW_MAX)) ? 7'(ROW_MAX) : r_row_len);
    assign w_idx    = (r_count < CW'(ROW_MAX)) ? r_count[AW-1:0] : AW'(ROW_MAX - 1);

    assign o_status.row_done  = w_accept && ((7'(w_idx) + 7'd1) >= w_len);
    assign o_status.last_elem = (CW'(r_k) + CW'(1)) == r_count;
    assign o_status.out_free  = !o_valid || i_m_tready;
    assign o_status.backward  = r_mode;

    l2n_ram #(
        .WIDTH(32),
        .DEPTH(ROW_MAX)
    ) u_buf (
        .i_clk  (i_clk),
        .i_we   (w_accept),
        .i_waddr(w_idx),
        .i_wdata(i_s_tdata),
        .i_raddr(r_k),
        .o_rdata(w_rd)
    );

    assign w_rb  = r_sres + r_sbit;
    assign w_tg  = r_mg[0] ? r_ms : 56'sd0;
    assign w_tx  = r_mx[0] ? r_md : 56'sd0;
    assign w_ge  = {19'd0, r_rem} >= r_dsh;
    assign w_mag = r_mode ? (r_acc[55] ? 56'(-r_acc) : 56'(r_acc))
                          : (r_x[15] ? 56'(-32'(r_x)) : 56'(r_x));

    assign w_round = {r_rem, 1'b0} >= 86'(r_dv);
    assign w_qr    = 36'(r_q) + 36'(w_round);
    assign w_lim   = r_neg ? 36'h080000000 : 36'h07FFFFFFF;
    assign w_sat   = r_ovf || (w_qr > w_lim);
    assign w_m     = w_sat ? w_lim : w_qr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= 1'b0;
            r_row_len <= 7'd64;
            r_ssum    <= '0;
            r_dsum    <= '0;
            r_count   <= '0;
            r_seen    <= 1'b0;
            r_k       <= '0;
            o_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    l2n_pkg::REG_MODE:       r_mode    <= i_cfg_data[0];
                    l2n_pkg::REG_ROW_LENGTH: r_row_len <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_ssum  <= r_ssum + 37'($unsigned(w_sq));
                r_dsum  <= r_dsum + 38'(w_xg);
                r_seen  <= r_seen | i_s_tlast;
                r_count <= CW'(w_idx) + CW'(1);
            end
            if (i_cmd.emit) begin
                o_valid <= 1'b1;
                if (o_status.last_elem) begin
                    r_ssum  <= '0;
                    r_dsum  <= '0;
                    r_count <= '0;
                    r_seen  <= 1'b0;
                    r_k     <= '0;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end else if (i_m_tready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_sc   <= (r_ssum == '0) ? 37'd1 : r_ssum;
            r_sv   <= {1'b0, ((r_ssum == '0) ? 37'd1 : r_ssum), 26'd0};
            r_sres <= '0;
            r_sbit <= 64'h4000000000000000;
        end
        if (i_cmd.sqrt_step) begin
            if (r_sv >= w_rb) begin
                r_sv   <= r_sv - w_rb;
                r_sres <= (r_sres >> 1) + r_sbit;
            end else begin
                r_sres <= r_sres >> 1;
            end
            r_sbit <= r_sbit >> 2;
        end
        if (i_cmd.den_init) begin
            r_den <= '0;
            r_ssh <= 69'(r_sc);
            r_rsh <= r_sres[31:0];
        end
        if (i_cmd.den_step) begin
            if (r_rsh[0]) begin
                r_den <= r_den + r_ssh;
            end
            r_ssh <= r_ssh << 1;
            r_rsh <= r_rsh >> 1;
        end
        if (i_cmd.num_init) begin
            r_x   <= w_rd[15:0];
            r_mx  <= w_rd[15:0];
            r_mg  <= w_rd[31:16];
            r_ms  <= 56'(r_sc);
            r_md  <= 56'(r_dsum);
            r_acc <= '0;
        end
        if (i_cmd.num_step) begin
            if (i_cmd.num_last) begin
                r_acc <= r_acc - w_tg + w_tx;
            end else begin
                r_acc <= r_acc + w_tg - w_tx;
            end
            r_ms <= r_ms <<< 1;
            r_md <= r_md <<< 1;
            r_mx <= r_mx >> 1;
            r_mg <= r_mg >> 1;
        end
        if (i_cmd.quo_init) begin
            r_neg <= r_mode ? r_acc[55] : r_x[15];
            r_rem <= {w_mag[55:0], 29'd0};
            r_dsh <= {(r_mode ? r_den : 69'(r_sres[31:0])), 35'd0};
            r_dv  <= r_mode ? r_den : 69'(r_sres[31:0]);
            r_q   <= '0;
            r_ovf <= 1'b0;
        end
        if (i_cmd.div_step) begin
            if (i_cmd.div_first) begin
                r_ovf <= w_ge;
            end else begin
                if (w_ge) begin
                    r_rem <= r_rem - r_dsh[84:0];
                end
                r_q <= {r_q[33:0], w_ge};
            end
            r_dsh <= r_dsh >> 1;
        end
        if (i_cmd.emit) begin
            o_value <= r_neg ? (32'd0 - w_m[31:0]) : w_m[31:0];
            o_index <= 6'(r_k);
            o_last  <= o_status.last_elem;
            o_batch <= o_status.last_elem && r_seen;
            o_sat   <= w_sat;
        end
    end

endmodule
`default_nettype wire

### design/l2_row_normalize.sv
// Row L2 normalization: a row of n elements loads at one per cycle, then the root and the
// denominator product are computed. Each result then passes through the 16-step numerator
// multiply (backward mode only) and the 36-step shared divider. Input is held off from the
// row's last element until its last result enters the output register.
// Reset (synchronous, active low) clears sums, counts and handshakes; mode 0, length 64.
`default_nettype none
module l2_row_normalize #(
    parameter int unsigned ROW_MAX = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire         i_cfg_index,
    input  wire  [6:0]  i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // feature [15:0], gradient [31:16]
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // out_value [31:0], element_index [37:32], zeros
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser    // batch_done [0], saturated [1]
);

    l2n_pkg::t_cmd    w_cmd;
    l2n_pkg::t_status w_status;
    logic [31:0]      w_value;
    logic [5:0]       w_index;

    l2n_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_status(w_status),
        .o_cmd   (w_cmd)
    );

    l2n_dp #(
        .ROW_MAX(ROW_MAX)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tlast  (s_axis_tlast),
        .i_m_tready (m_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_value    (w_value),
        .o_index    (w_index),
        .o_last     (m_axis_tlast),
        .o_batch    (m_axis_tuser[0]),
        .o_sat      (m_axis_tuser[1])
    );

    assign s_axis_tready = w_cmd.load_en;
    assign m_axis_tdata  = {2'b00, w_index, w_value};

endmodule
`default_nettype wire

### tb/l2_row_normalize_tb.sv
// Testbench for l2_row_normalize: streams feature/gradient rows through the block and
// checks every normalized output against a bit-exact predictor built into this file.
// Depends on the l2n_pkg package and the l2_row_normalize RTL only.
`timescale 1ns / 1ps
`default_nettype none
module l2_row_normalize_tb;

    localparam int unsigned ROWS_MAX  = 64;
    localparam int unsigned RAND_ITEMS = 480;
    localparam longint unsigned CYCLE_LIMIT = 3000000;
    localparam logic MODE_FWD = 1'b0;
    localparam logic MODE_BWD = 1'b1;

    typedef struct {
        logic signed [15:0] feature;
        logic signed [15:0] gradient;
        logic               batch_end;
    } t_elem;

    typedef struct {
        logic [31:0] value;
        logic [5:0]  index;
        logic        row_last;
        logic        batch_done;
        logic        saturated;
    } t_norm;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic        i_cfg_index;
    logic [6:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;

    t_elem elem_queue[$];
    t_norm norm_queue[$];
    int unsigned error_count;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned stall_req;
    int unsigned stall_ack;
    int unsigned stall_left;
    longint unsigned cycle_count;

    logic        cur_mode;
    logic [6:0]  cur_length;
    logic [15:0] feat_buf[ROWS_MAX];
    logic [15:0] grad_buf[ROWS_MAX];
    longint unsigned sq_acc;
    longint          dot_acc;
    int unsigned     elem_cnt;
    logic            batch_seen;

    l2_row_normalize i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Rounds mag * 2^29 / den to nearest, halves away from zero, then saturates.
    function automatic void scale_round(input logic [63:0] mag, input logic neg,
                                        input logic [127:0] den, output logic [31:0] val,
                                        output logic sat);
        logic [127:0] num;
        logic [127:0] q;
        logic [127:0] r;
        logic [127:0] lim;
        num = {64'd0, mag} << 29;
        q = num / den;
        r = num % den;
        if ((r << 1) >= den) q = q + 1;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        sat = 1'b0;
        if (q > lim) begin
            q = lim;
            sat = 1'b1;
        end
        val = neg ? (32'd0 - q[31:0]) : q[31:0];
    endfunction

    task automatic normalize_element(input t_elem e);
        int unsigned idx;
        int unsigned len;
        longint unsigned s;
        longint unsigned root;
        longint signed xv;
        longint signed gv;
        longint signed num;
        logic [63:0] mag;
        logic [127:0] den;
        t_norm o;
        idx = (elem_cnt < ROWS_MAX) ? elem_cnt : ROWS_MAX - 1;
        len = (cur_length == 0) ? 1 : ((cur_length > ROWS_MAX) ? ROWS_MAX : cur_length);
        feat_buf[idx] = e.feature;
        grad_buf[idx] = e.gradient;
        xv = e.feature;
        gv = e.gradient;
        sq_acc = (sq_acc + longint'(xv * xv)) & ((64'd1 << 37) - 1);
        dot_acc = dot_acc + xv * gv;
        batch_seen = batch_seen | e.batch_end;
        elem_cnt = idx + 1;
        if (elem_cnt < len) return;
        s = (sq_acc == 0) ? 1 : sq_acc;
        root = int_sqrt(s << 26);
        for (int k = 0; k < elem_cnt; k++) begin
            xv = $signed(feat_buf[k]);
            gv = $signed(grad_buf[k]);
            if (cur_mode == MODE_FWD) begin
                mag = (xv < 0) ? -xv : xv;
                den = {64'd0, root};
                scale_round(mag, xv < 0, den, o.value, o.saturated);
            end else begin
                num = gv * longint'(s) - xv * dot_acc;
                mag = (num < 0) ? -num : num;
                den = {64'd0, s} * {64'd0, root};
                scale_round(mag, num < 0, den, o.value, o.saturated);
            end
            o.index = k[5:0];
            o.row_last = (k == elem_cnt - 1);
            o.batch_done = (k == elem_cnt - 1) && batch_seen;
            norm_queue.push_back(o);
        end
        sq_acc = 0;
        dot_acc = 0;
        elem_cnt = 0;
        batch_seen = 1'b0;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Source side.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (elem_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                t_elem e;
                e = elem_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {e.gradient, e.feature};
                s_axis_tlast <= e.batch_end;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Sink side, with a single long hold-off.
    always @(posedge i_clk) begin
        if (stall_req != stall_ack) begin
            stall_ack = stall_req;
            stall_left = 600;
        end
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (norm_queue.size() == 0) begin
                report_mismatch("unexpected transaction", m_axis_tdata[31:0], 0);
            end else begin
                t_norm w;
                w = norm_queue.pop_front();
                if (m_axis_tdata[31:0] !== w.value)
                    report_mismatch("out_value", $signed(m_axis_tdata[31:0]), $signed(w.value));
                if (m_axis_tdata[37:32] !== w.index)
                    report_mismatch("element_index", m_axis_tdata[37:32], w.index);
                if (m_axis_tlast !== w.row_last)
                    report_mismatch("row_last", m_axis_tlast, w.row_last);
                if (m_axis_tuser[0] !== w.batch_done)
                    report_mismatch("batch_done", m_axis_tuser[0], w.batch_done);
                if (m_axis_tuser[1] !== w.saturated)
                    report_mismatch("saturated", m_axis_tuser[1], w.saturated);
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            t_elem e;
            e.feature = s_axis_tdata[15:0];
            e.gradient = s_axis_tdata[31:16];
            e.batch_end = s_axis_tlast;
            normalize_element(e);
        end
    end

    task automatic write_reg(input logic index, input logic [6:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        if (index == l2n_pkg::REG_MODE) cur_mode = data[0];
        else cur_length = data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_sent();
        while (elem_queue.size() > 0 || s_axis_tvalid) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        wait_sent();
        while (norm_queue.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic add_elem(input logic [15:0] x, input logic [15:0] g, input logic be);
        t_elem e;
        e.feature = x;
        e.gradient = g;
        e.batch_end = be;
        elem_queue.push_back(e);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 4))
            0: return 16'($urandom());
            1: return 16'($signed($urandom_range(0, 30)) - 15);
            2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            3: return 16'd0;
            default: return $urandom_range(0, 1) ? 16'($urandom_range(0, 4095))
                                                 : 16'(-$urandom_range(1, 4096));
        endcase
    endfunction

    initial begin
        int unsigned sent;
        int unsigned len;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = l2n_pkg::REG_MODE;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        error_count = 0;
        cycle_count = 0;
        stall_req = 0;
        stall_ack = 0;
        stall_left = 0;
        send_idle_pct = 7;
        recv_idle_pct = 77;
        cur_mode = MODE_FWD;
        cur_length = 7'd64;
        sq_acc = 0;
        dot_acc = 0;
        elem_cnt = 0;
        batch_seen = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Single-element rows: the zero row takes the clamped sum.
        write_reg(l2n_pkg::REG_ROW_LENGTH, 7'd1);
        add_elem(16'h0000, 16'h0000, 1'b0);
        add_elem(16'h8000, 16'h7FFF, 1'b0);
        add_elem(16'h7FFF, 16'h8000, 1'b1);
        wait_drained();
        write_reg(l2n_pkg::REG_MODE, 7'(MODE_BWD));
        add_elem(16'h0000, 16'h7FFF, 1'b0);
        add_elem(16'h0001, 16'h8000, 1'b1);
        wait_drained();
        // Early batch end, extremes in backward mode.
        write_reg(l2n_pkg::REG_ROW_LENGTH, 7'd3);
        add_elem(16'h8000, 16'h8000, 1'b1);
        add_elem(16'h7FFF, 16'hFFFF, 1'b0);
        add_elem(16'h0001, 16'h7FFF, 1'b0);
        wait_drained();
        // Mode and length changed in the middle of a row.
        add_elem(16'h1234, 16'hF00D, 1'b0);
        wait_sent();
        write_reg(l2n_pkg::REG_MODE, 7'(MODE_FWD));
        write_reg(l2n_pkg::REG_ROW_LENGTH, 7'd5);
        add_elem(16'hC000, 16'h0400, 1'b0);
        add_elem(16'h0800, 16'h0002, 1'b1);
        wait_sent();
        write_reg(l2n_pkg::REG_ROW_LENGTH, 7'd2);
        add_elem(16'h0003, 16'h0003, 1'b0);
        wait_drained();
        // Zero length acts as one.
        write_reg(l2n_pkg::REG_ROW_LENGTH, 7'd0);
        add_elem(16'h4000, 16'h0000, 1'b1);
        wait_drained();
        // Full row from an oversize length.
        write_reg(l2n_pkg::REG_ROW_LENGTH, 7'd127);
        for (int i = 0; i < 64; i++) add_elem(pick_value(), pick_value(), i == 63);
        wait_drained();

        sent = 0;
        stall_req = stall_req + 1;
        while (sent < RAND_ITEMS) begin
            if (sent >= RAND_ITEMS / 3 && send_idle_pct == 7) begin
                send_idle_pct = 77;
                recv_idle_pct = 7;
            end else if (sent >= 2 * RAND_ITEMS / 3 && send_idle_pct == 77) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(0, 3) == 0) begin
                wait_drained();
                write_reg(l2n_pkg::REG_MODE, 7'($urandom_range(0, 1)));
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 64)
                                                   : $urandom_range(1, 8);
                write_reg(l2n_pkg::REG_ROW_LENGTH, len[6:0]);
            end
            len = (cur_length == 0) ? 1 : ((cur_length > 64) ? 64 : cur_length);
            for (int r = 0; r < 3; r++) begin
                for (int i = 0; i < len; i++) begin
                    add_elem(pick_value(), pick_value(),
                             (i == len - 1) ? ($urandom_range(0, 3) == 0)
                                            : ($urandom_range(0, 15) == 0));
                end
                sent = sent + len;
            end
        end
        wait_drained();
        repeat (200) @(posedge i_clk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
